@@ hdl/lsdc_pkg.sv @@
package lsdc_pkg;

   localparam int TABLE_SIZE       = 131072;
   localparam int PRIME_LIST_DEPTH = 16384;
   localparam int VALUE_W          = 17;
   localparam int ADDR_W           = $clog2(TABLE_SIZE);
   localparam int PIDX_W           = $clog2(PRIME_LIST_DEPTH);
   localparam int TOTAL_W          = 15;
   localparam int COUNT_W          = 8;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 15'h7FFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_READY = 2'd1,
      STATUS_ZERO      = 2'd2
   } status_type;

   localparam logic ACTION_BUILD = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MARK_RD,
      ST_MARK_CHK,
      ST_MARK_MUL,
      ST_MARK_WR,
      ST_Q_RD,
      ST_Q_CHK,
      ST_Q_DIV,
      ST_DONE
   } state_type;

endpackage

@@ hdl/linear_sieve_divisor_counter_core.sv @@
// Linear sieve smallest-prime-factor table with divisor-count queries.
// req_ channel: tuser carries the action and tdata the query value. One item
// is accepted when the block is idle and no result is waiting.
// Action 0 builds the table. A clearing pass over every entry comes first.
// Then a walk goes over every value i from 2: it reads the entry of i, and for
// each stored prime p, until i*p leaves the table or p divides i, it reads p,
// multiplies i*p, writes the entry at i*p and checks p | i with a bit-serial
// remainder. Action 1 queries one value. For each distinct prime factor it
// reads the table entry and checks it, then runs one bit-serial division more
// than the factor's exponent. A query that fails the ready or the zero check
// answers in the cycle after it is accepted. One item is in work at a time.
// The result is held in an output register on rsp_ until rsp_tready is
// high. The next item is taken only after the result is delivered.
// Reset clears the ready flag and the prime count. The memories are not
// cleared, and queries before the first build report STATUS_NOT_READY.
module linear_sieve_divisor_counter_core
   import lsdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,  // [0] action
   input  logic [23:0] req_tdata,  // [16:0] query_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // [1:0] status, [9:2] divisor_count,
                                   // [26:10] smallest_factor,
                                   // [27] value_is_prime, [42:28] primes_found
);

   logic [VALUE_W-1:0] ftab [TABLE_SIZE];
   logic [VALUE_W-1:0] plist [PRIME_LIST_DEPTH];

   state_type state_ff, state_in;

   logic               ready_ff, ready_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [PIDX_W:0]    stored_ff, stored_in;
   logic [ADDR_W:0]    i_ff, i_in;
   logic [PIDX_W:0]    k_ff, k_in;
   logic [VALUE_W-1:0] p_ff, p_in;
   logic [ADDR_W+VALUE_W-1:0] prod_ff, prod_in;
   logic [VALUE_W-1:0] x_ff, x_in;
   logic [VALUE_W-1:0] f_ff, f_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in, base_ff, base_in;
   logic [VALUE_W-1:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [4:0]         dstep_ff, dstep_in;
   logic               dmode_ff, dmode_in; // 0: check i % p, 1: query division
   logic               rvalid_ff, rvalid_in;
   logic [47:0]        rdata_ff, rdata_in;

   // memory port controls
   logic               fwr_en, prd_en;
   logic [ADDR_W-1:0]  faddr;
   logic [VALUE_W-1:0] fwdata, frd_ff, prd_ff;
   logic [PIDX_W-1:0]  paddr;
   logic               pwr_en;

   always_ff @(posedge clock) begin
      if (fwr_en) begin
         ftab[faddr] <= fwdata;
      end
      frd_ff <= ftab[faddr];
   end

   always_ff @(posedge clock) begin
      if (pwr_en) begin
         plist[paddr] <= fwdata;
      end
      if (prd_en) begin
         prd_ff <= plist[paddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ready_ff  <= 1'b0;
         total_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ready_ff  <= ready_in;
         total_ff  <= total_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      stored_ff <= stored_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
      p_ff      <= p_in;
      prod_ff   <= prod_in;
      x_ff      <= x_in;
      f_ff      <= f_in;
      cnt_ff    <= cnt_in;
      base_ff   <= base_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dstep_ff  <= dstep_in;
      dmode_ff  <= dmode_in;
      rdata_ff  <= rdata_in;
   end

   logic [VALUE_W:0]   trial;
   logic [VALUE_W-1:0] dividend;
   logic [VALUE_W-1:0] qv;
   logic [COUNT_W:0]   csum;

   always_comb begin
      state_in  = state_ff;
      ready_in  = ready_ff;
      total_in  = total_ff;
      rvalid_in = rvalid_ff;
      stored_in = stored_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      p_in      = p_ff;
      prod_in   = prod_ff;
      x_in      = x_ff;
      f_in      = f_ff;
      cnt_in    = cnt_ff;
      base_in   = base_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dstep_in  = dstep_ff;
      dmode_in  = dmode_ff;
      rdata_in  = rdata_ff;
      fwr_en    = 1'b0;
      pwr_en    = 1'b0;
      prd_en    = 1'b0;
      faddr     = i_ff[ADDR_W-1:0];
      fwdata    = '0;
      paddr     = k_ff[PIDX_W-1:0];
      req_tready = 1'b0;
      qv        = req_tdata[VALUE_W-1:0];
      dividend  = dmode_ff ? x_ff : i_ff[VALUE_W-1:0];
      trial     = {rem_ff, dividend[5'(VALUE_W-1) - dstep_ff]};
      csum      = {1'b0, cnt_ff} + {1'b0, base_ff};

      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = !rvalid_ff;
            if (req_tvalid && !rvalid_ff) begin
               if (req_tuser == ACTION_BUILD) begin
                  ready_in  = 1'b0;
                  total_in  = '0;
                  stored_in = '0;
                  i_in      = '0;
                  state_in  = ST_CLEAR;
               end else if (!ready_ff || 32'(qv) >= TABLE_SIZE) begin
                  rdata_in  = {5'd0, total_ff, 26'd0, STATUS_NOT_READY};
                  rvalid_in = 1'b1;
               end else if (qv == '0) begin
                  rdata_in  = {5'd0, total_ff, 26'd0, STATUS_ZERO};
                  rvalid_in = 1'b1;
               end else begin
                  x_in     = qv;
                  cnt_in   = 8'd1;
                  rdata_in = '0;
                  dmode_in = 1'b1;
                  state_in = ST_Q_RD;
               end
            end
         end
         ST_CLEAR: begin
            fwr_en = 1'b1;
            i_in   = i_ff + 1'b1;
            if (32'(i_ff) == TABLE_SIZE - 1) begin
               i_in     = (ADDR_W+1)'(2);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (32'(i_ff) >= TABLE_SIZE) begin
               ready_in  = 1'b1;
               rdata_in  = {5'd0, total_ff, 26'd0, STATUS_OK};
               rvalid_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (frd_ff == '0) begin
               fwr_en = 1'b1;
               fwdata = i_ff[VALUE_W-1:0];
               if (32'(stored_ff) < PRIME_LIST_DEPTH) begin
                  pwr_en    = 1'b1;
                  paddr     = stored_ff[PIDX_W-1:0];
                  stored_in = stored_ff + 1'b1;
               end
               if (total_ff != TOTAL_MAX) begin
                  total_in = total_ff + 1'b1;
               end
            end
            k_in     = '0;
            state_in = ST_MARK_RD;
         end
         ST_MARK_RD: begin
            if (k_ff >= stored_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN_RD;
               faddr    = i_in[ADDR_W-1:0];
            end else begin
               prd_en   = 1'b1;
               state_in = ST_MARK_MUL;
            end
         end
         ST_MARK_MUL: begin
            p_in     = prd_ff;
            prod_in  = i_ff[ADDR_W-1:0] * prd_ff;
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            if (prod_ff >= (ADDR_W+VALUE_W)'(TABLE_SIZE)) begin
               i_in     = i_ff + 1'b1;
               faddr    = i_in[ADDR_W-1:0];
               state_in = ST_SCAN_RD;
            end else begin
               fwr_en   = 1'b1;
               faddr    = prod_ff[ADDR_W-1:0];
               fwdata   = p_ff;
               f_in     = p_ff;
               dmode_in = 1'b0;
               rem_in   = '0;
               dstep_in = '0;
               state_in = ST_MARK_CHK;
            end
         end
         ST_MARK_CHK: begin
            // Bit-serial remainder of i by p.
            rem_in = (trial >= {1'b0, f_ff}) ? VALUE_W'(trial - {1'b0, f_ff})
                                             : trial[VALUE_W-1:0];
            dstep_in = dstep_ff + 1'b1;
            if (32'(dstep_ff) == VALUE_W - 1) begin
               if (rem_in == '0) begin
                  i_in     = i_ff + 1'b1;
                  faddr    = i_in[ADDR_W-1:0];
                  state_in = ST_SCAN_RD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_MARK_RD;
               end
            end
         end
         ST_Q_RD: begin
            faddr = x_ff[ADDR_W-1:0];
            if (x_ff <= VALUE_W'(1)) begin
               rdata_in[1:0]   = STATUS_OK;
               rdata_in[9:2]   = cnt_ff;
               rdata_in[42:28] = total_ff;
               rvalid_in       = 1'b1;
               state_in        = ST_DONE;
            end else begin
               state_in = ST_Q_CHK;
            end
         end
         ST_Q_CHK: begin
            if (rdata_in[26:10] == '0) begin
               rdata_in[26:10] = frd_ff;
               rdata_in[27]    = (frd_ff == x_ff);
            end
            if (frd_ff < VALUE_W'(2)) begin
               x_in     = VALUE_W'(1);
               state_in = ST_Q_RD;
            end else begin
               f_in     = frd_ff;
               base_in  = cnt_ff;
               rem_in   = '0;
               quo_in   = '0;
               dstep_in = '0;
               state_in = ST_Q_DIV;
            end
         end
         ST_Q_DIV: begin
            if (trial >= {1'b0, f_ff}) begin
               rem_in = VALUE_W'(trial - {1'b0, f_ff});
               quo_in = {quo_ff[VALUE_W-2:0], 1'b1};
            end else begin
               rem_in = trial[VALUE_W-1:0];
               quo_in = {quo_ff[VALUE_W-2:0], 1'b0};
            end
            dstep_in = dstep_ff + 1'b1;
            if (32'(dstep_ff) == VALUE_W - 1) begin
               rem_in   = '0;
               quo_in   = '0;
               dstep_in = '0;
               // The last step leaves no remainder when trial is zero or f.
               if (trial == '0 || trial == {1'b0, f_ff}) begin
                  // f divides x: take the quotient and divide again.
                  x_in   = {quo_ff[VALUE_W-2:0], (trial >= {1'b0, f_ff})};
                  cnt_in = csum[COUNT_W] ? COUNT_MAX : csum[COUNT_W-1:0];
               end else begin
                  state_in = ST_Q_RD;
               end
            end
         end
         ST_DONE: begin
            if (!rvalid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("item accepted while busy");
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_ready_after_build: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !ready_ff)
      else $error("table ready during build");
`endif

endmodule

@@ dv/linear_sieve_divisor_counter_core_tb.sv @@
module linear_sieve_divisor_counter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lsdc_pkg::*;

   localparam int IDLE_LIMIT = 16000000;

   typedef struct packed {
      logic                 action;
      logic [VALUE_W-1:0]   value;
   } query_item_type;

   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   divisors;
      logic [VALUE_W-1:0]   factor;
      logic                 is_prime;
      logic [TOTAL_W-1:0]   primes;
   } answer_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   query_item_type  pending_items[$];
   answer_item_type expected_answers[$];
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         error_count = 0;
   int         idle_cycles = 0;

   // Predictor state.
   int unsigned  spf_table[TABLE_SIZE];
   logic         table_built = 1'b0;
   int unsigned  prime_count = 0;

   linear_sieve_divisor_counter_core dut (.*);

   always #5 clock = ~clock;

   function automatic void build_spf();
      for (int i = 0; i < TABLE_SIZE; i++) spf_table[i] = 0;
      prime_count = 0;
      for (int i = 2; i < TABLE_SIZE; i++) begin
         if (spf_table[i] == 0) begin
            spf_table[i] = i;
            if (prime_count < TOTAL_MAX) prime_count++;
            if (longint'(i) * i < TABLE_SIZE) begin
               for (int m = i * i; m < TABLE_SIZE; m += i)
                  if (spf_table[m] == 0) spf_table[m] = i;
            end
         end
      end
      table_built = 1'b1;
   endfunction

   function automatic answer_item_type predict_divisors(query_item_type q);
      answer_item_type a;
      int unsigned x, f, base, cnt;
      a = '0;
      a.status = STATUS_OK;
      if (q.action == ACTION_BUILD) begin
         build_spf();
      end else if (!table_built) begin
         a.status = STATUS_NOT_READY;
      end else if (q.value == 0) begin
         a.status = STATUS_ZERO;
      end else begin
         x = q.value;
         cnt = 1;
         if (x >= 2) begin
            a.factor = VALUE_W'(spf_table[x]);
            a.is_prime = (spf_table[x] == x);
         end
         while (x > 1) begin
            f = spf_table[x];
            base = cnt;
            while (x % f == 0) begin
               x = x / f;
               cnt = cnt + base;
               if (cnt > COUNT_MAX) cnt = COUNT_MAX;
            end
         end
         a.divisors = COUNT_W'(cnt);
      end
      a.primes = TOTAL_W'(prime_count);
      return a;
   endfunction

   function automatic void enqueue_item(query_item_type q);
      pending_items.insert(pending_items.size(), q);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: keeps an item on the bus until it is taken.
   always @(posedge clock) begin
      query_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            item = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= item.action;
            req_tdata  <= {7'b0, item.value};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor and checker.
   always @(posedge clock) begin
      answer_item_type want, got;
      query_item_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.action = req_tuser;
            seen.value  = req_tdata[VALUE_W-1:0];
            expected_answers.insert(expected_answers.size(), predict_divisors(seen));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = answer_item_type'({rsp_tdata[1:0], rsp_tdata[9:2], rsp_tdata[26:10],
                                     rsp_tdata[27], rsp_tdata[42:28]});
            if (expected_answers.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = expected_answers.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.divisors !== want.divisors)
                  report_mismatch("divisor_count", got.divisors, want.divisors);
               if (got.factor !== want.factor)
                  report_mismatch("smallest_factor", got.factor, want.factor);
               if (got.is_prime !== want.is_prime)
                  report_mismatch("value_is_prime", got.is_prime, want.is_prime);
               if (got.primes !== want.primes)
                  report_mismatch("primes_found", got.primes, want.primes);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic query_item_type make_query(int unsigned v);
      query_item_type q;
      q.action = ACTION_QUERY;
      q.value = VALUE_W'(v);
      return q;
   endfunction

   function automatic int unsigned random_value();
      int unsigned v;
      case ($urandom_range(5))
         0: v = $urandom_range(30);
         1: v = 1 << $urandom_range(16);
         2: v = $urandom_range(2000);
         // Products of small primes give large divisor counts.
         3: begin
            v = 1;
            repeat ($urandom_range(12)) begin
               case ($urandom_range(3))
                  0: v = v * 2;
                  1: v = v * 3;
                  2: v = v * 5;
                  default: v = v * 7;
               endcase
            end
         end
         default: v = $urandom_range(TABLE_SIZE - 1);
      endcase
      return v % TABLE_SIZE;
   endfunction

   initial begin
      query_item_type build_item;
      int corner_values[12];
      corner_values = '{0, 1, 2, 3, 4, 131071, 131070, 65536, 110880, 83160, 121, 97};
      build_item = '0;
      build_item.action = ACTION_BUILD;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Queries before the table exists, then a build and corner values.
      enqueue_item(make_query(0));
      enqueue_item(make_query(1));
      enqueue_item(make_query(TABLE_SIZE - 1));
      enqueue_item(build_item);
      foreach (corner_values[i])
         enqueue_item(make_query(corner_values[i]));
      // A second build must leave the same table.
      enqueue_item(build_item);
      enqueue_item(make_query(1));
      enqueue_item(make_query(131071));
      enqueue_item(make_query(98280));

      for (int phase = 0; phase < 3; phase++) begin
         wait (pending_items.size() == 0);
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 54 : 0;
         recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 31 : 0;
         for (int n = 0; n < 160; n++) enqueue_item(make_query(random_value()));
      end

      wait (pending_items.size() == 0 && !req_tvalid && expected_answers.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
